### rtl/core/vart_pkg.sv
package vart_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int ANGLE_WIDTH  = 17;
  localparam int K_WIDTH      = 32;
  localparam int K_FRAC       = 30;
  localparam int FIFO_DEPTH   = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int DIV_W        = 31;
  localparam int RECIP_W      = 39;
  localparam int RECIP_LO     = 19;

  localparam int FULL_TURN    = 46080;
  localparam int THREE_QUART  = 34560;
  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;
  localparam int EIGHTH_TURN  = 5760;
  localparam longint RAD_PER_UNIT = 149922641;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [K_WIDTH-1:0]     coef_t;

  localparam coef_t ONE_Q30 = 32'sh4000_0000;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS  = 2'd1;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    coord_t vertex_z;
    logic   first_vertex;
    logic   last_vertex;
  } in_item_t;

  typedef struct packed {
    coord_t rotated_x;
    coord_t rotated_y;
    coord_t rotated_z;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
    logic   pass_done;
  } out_item_t;

  typedef struct packed {
    coef_t sine;
    coef_t cosine;
  } sc_pair_t;

  // classified item: the turning pair, the passing coordinate, its coefficients
  typedef struct packed {
    coord_t     a;
    coord_t     b;
    coord_t     p;
    coef_t      kc;
    coef_t      ks;
    coef_t      nks;
    logic [1:0] axis;
    logic       first;
    logic       last;
  } q_item_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_REDUCE,
    SC_THETA,
    SC_SQUARE,
    SC_MUL,
    SC_DIV,
    SC_ACC,
    SC_MAP
  } sc_state_t;

  // reciprocals of the taylor divisors n*(n+1): floor(2^39 / d) + 1,
  // exact floor quotient for any dividend below 2^31
  function automatic logic [RECIP_W-1:0] series_recip(input logic cos_ph,
                                                      input logic [2:0] k);
    logic [RECIP_W-1:0] m;
    m = '0;
    if (cos_ph) begin
      case (k)
        3'd0: m = 39'd274877906945;
        3'd1: m = 39'd45812984491;
        3'd2: m = 39'd18325193797;
        3'd3: m = 39'd9817068106;
        3'd4: m = 39'd6108397933;
        3'd5: m = 39'd4164816772;
        default: m = '0;
      endcase
    end else begin
      case (k)
        3'd0: m = 39'd91625968982;
        3'd1: m = 39'd27487790695;
        3'd2: m = 39'd13089424141;
        3'd3: m = 39'd7635497416;
        3'd4: m = 39'd4997780127;
        default: m = '0;
      endcase
    end
    return m;
  endfunction

endpackage

### rtl/core/vart_sincos.sv
module vart_sincos
  import vart_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output logic                   busy,
  output sc_pair_t               pair
);

  sc_state_t state_r, state_nxt;

  logic [ANGLE_WIDTH-1:0] angle_r;
  logic [1:0]             q_r;
  logic                   swap_r;
  logic [12:0]            r_r;
  logic [30:0]            theta_r;
  logic [29:0]            t2_r;
  logic [30:0]            term_r;
  logic [DIV_W-1:0]       div_r;
  logic                   div_ph_r;
  logic [50:0]            ph_r;
  logic [49:0]            pl_r;
  logic [2:0]             k_r;
  logic                   cos_ph_r;
  logic signed [32:0]     sacc_r;
  logic signed [32:0]     cacc_r;
  sc_pair_t               pair_r;

  // angle reduction into quadrant and octant-folded remainder
  logic signed [18:0] a0, am;
  logic [15:0]        am_u;
  logic [1:0]         q_c;
  logic [15:0]        r_c;
  logic               swap_c;
  logic [12:0]        rr_c;

  always_comb begin
    a0 = {{2{angle_r[ANGLE_WIDTH-1]}}, angle_r};
    if (a0 < -19'sd46080)      am = a0 + 19'sd92160;
    else if (a0 < 19'sd0)      am = a0 + 19'sd46080;
    else if (a0 >= 19'sd46080) am = a0 - 19'sd46080;
    else                       am = a0;
    am_u = am[15:0];
    if (am_u >= 16'(THREE_QUART)) begin
      q_c = 2'd3;
      r_c = am_u - 16'(THREE_QUART);
    end else if (am_u >= 16'(HALF_TURN)) begin
      q_c = 2'd2;
      r_c = am_u - 16'(HALF_TURN);
    end else if (am_u >= 16'(QUARTER_TURN)) begin
      q_c = 2'd1;
      r_c = am_u - 16'(QUARTER_TURN);
    end else begin
      q_c = 2'd0;
      r_c = am_u;
    end
    swap_c = r_c > 16'(EIGHTH_TURN);
    rr_c   = swap_c ? 13'(16'(QUARTER_TURN) - r_c) : r_c[12:0];
  end

  logic [41:0]        th_full;
  logic [61:0]        sq_full;
  logic [60:0]        prod_full;
  logic [RECIP_W-1:0] recip;
  logic [50:0]        ph_full;
  logic [49:0]        pl_full;
  logic [69:0]        qprod;
  logic               last_term;

  assign th_full   = 42'(r_r) * 42'(RAD_PER_UNIT) + 42'd512;
  assign sq_full   = 62'(theta_r) * 62'(theta_r);
  assign prod_full = 61'(term_r) * 61'(t2_r);
  // divide by the term divisor as a reciprocal multiply, split in two halves
  assign recip     = series_recip(cos_ph_r, k_r);
  assign ph_full   = 51'(div_r) * 51'(recip[RECIP_W-1:RECIP_LO]);
  assign pl_full   = 50'(div_r) * 50'(recip[RECIP_LO-1:0]);
  assign qprod     = {ph_r, 19'd0} + 70'(pl_r);
  assign last_term = cos_ph_r && (k_r == 3'd5);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SC_IDLE:   state_nxt = SC_IDLE;
      SC_REDUCE: state_nxt = SC_THETA;
      SC_THETA:  state_nxt = SC_SQUARE;
      SC_SQUARE: state_nxt = SC_MUL;
      SC_MUL:    state_nxt = SC_DIV;
      SC_DIV:    if (div_ph_r) state_nxt = SC_ACC;
      SC_ACC:    state_nxt = last_term ? SC_MAP : SC_MUL;
      SC_MAP:    state_nxt = SC_IDLE;
      default:   state_nxt = SC_IDLE;
    endcase
    if (start) state_nxt = SC_REDUCE;
  end

  always_comb begin
    busy = (state_r != SC_IDLE);
    pair = pair_r;
  end

  logic signed [32:0] s_sel, c_sel;
  coef_t              s_f, c_f;
  logic signed [32:0] qv;

  assign s_sel = swap_r ? cacc_r : sacc_r;
  assign c_sel = swap_r ? sacc_r : cacc_r;
  assign s_f   = s_sel[31:0];
  assign c_f   = c_sel[31:0];
  assign qv    = $signed({2'b00, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      pair_r  <= '{sine: '0, cosine: ONE_Q30};
    end else begin
      state_r <= state_nxt;
      if (state_r == SC_MAP) begin
        case (q_r)
          2'd0:    pair_r <= '{sine: s_f,  cosine: c_f};
          2'd1:    pair_r <= '{sine: c_f,  cosine: -s_f};
          2'd2:    pair_r <= '{sine: -s_f, cosine: -c_f};
          default: pair_r <= '{sine: -c_f, cosine: s_f};
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) angle_r <= angle;
    case (state_r)
      SC_REDUCE: begin
        q_r    <= q_c;
        swap_r <= swap_c;
        r_r    <= rr_c;
      end
      SC_THETA: theta_r <= th_full[40:10];
      SC_SQUARE: begin
        t2_r     <= sq_full[59:30];
        term_r   <= theta_r;
        sacc_r   <= $signed({2'b00, theta_r});
        cacc_r   <= 33'(ONE_Q30);
        k_r      <= 3'd0;
        cos_ph_r <= 1'b0;
      end
      SC_MUL: begin
        div_r    <= prod_full[60:30];
        div_ph_r <= 1'b0;
      end
      SC_DIV: begin
        // partial products are registered first, then summed and shifted
        if (!div_ph_r) begin
          ph_r <= ph_full;
          pl_r <= pl_full;
        end else begin
          div_r <= qprod[69:39];
        end
        div_ph_r <= ~div_ph_r;
      end
      SC_ACC: begin
        // odd terms subtract, even terms add
        if (cos_ph_r) cacc_r <= k_r[0] ? cacc_r + qv : cacc_r - qv;
        else          sacc_r <= k_r[0] ? sacc_r + qv : sacc_r - qv;
        if (!cos_ph_r && k_r == 3'd4) begin
          cos_ph_r <= 1'b1;
          k_r      <= 3'd0;
          term_r   <= 31'h4000_0000;
        end else begin
          k_r    <= k_r + 3'd1;
          term_r <= div_r;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/vart_front.sv
module vart_front
  import vart_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  in_item_t   in_item,
  output logic       in_stall,
  input  logic       axis_we,
  input  logic [1:0] axis_wdata,
  input  logic       sc_busy,
  input  sc_pair_t   sc_pair,
  input  logic       fifo_full,
  output logic       push,
  output q_item_t    push_item
);

  logic [1:0] axis_r;
  logic       idle_r;
  sc_pair_t   act_r;
  sc_pair_t   kp;
  logic       accept;

  assign in_stall = sc_busy || fifo_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept;

  // coefficients latch when a pass opens
  assign kp = idle_r ? sc_pair : act_r;

  always_comb begin
    push_item.first = in_item.first_vertex;
    push_item.last  = in_item.last_vertex;
    push_item.axis  = axis_r;
    case (axis_r)
      AXIS_X: begin
        push_item.a = in_item.vertex_y;
        push_item.b = in_item.vertex_z;
        push_item.p = in_item.vertex_x;
      end
      AXIS_Y: begin
        push_item.a = in_item.vertex_z;
        push_item.b = in_item.vertex_x;
        push_item.p = in_item.vertex_y;
      end
      default: begin
        push_item.a = in_item.vertex_x;
        push_item.b = in_item.vertex_y;
        push_item.p = in_item.vertex_z;
      end
    endcase
    if (axis_r == AXIS_X || axis_r == AXIS_Y || axis_r == AXIS_Z) begin
      push_item.kc  = kp.cosine;
      push_item.ks  = kp.sine;
      push_item.nks = -kp.sine;
    end else begin
      // identity turn: exact pass-through after rounding
      push_item.kc  = ONE_Q30;
      push_item.ks  = '0;
      push_item.nks = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= AXIS_X;
      idle_r <= 1'b1;
      act_r  <= '{sine: '0, cosine: ONE_Q30};
    end else begin
      if (axis_we) axis_r <= axis_wdata;
      if (accept) begin
        if (idle_r) act_r <= sc_pair;
        idle_r <= in_item.last_vertex;
      end
    end
  end

endmodule

### rtl/core/vart_fifo.sv
module vart_fifo
  import vart_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t wdata,
  output logic    full,
  input  logic    pop,
  output q_item_t rdata,
  output logic    nonempty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign nonempty = (count_r != '0);
  assign rdata    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

endmodule

### rtl/core/vart_back.sv
module vart_back
  import vart_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fifo_valid,
  input  q_item_t   fifo_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int LO_W = COORD_WIDTH / 2;
  localparam int HI_W = COORD_WIDTH - LO_W;
  localparam int PH_W = HI_W + K_WIDTH;
  localparam int PL_W = LO_W + 1 + K_WIDTH;
  localparam int SW   = COORD_WIDTH + K_WIDTH + 2;
  localparam int RW   = SW - K_FRAC;

  localparam logic signed [RW-1:0] MAXV = RW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);
  localparam logic signed [SW-1:0] RND  = SW'(1) <<< (K_FRAC - 1);

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;

  // whole line moves when the output slot is free
  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && fifo_valid;

  // stage 1
  q_item_t s1_r;

  logic signed [HI_W-1:0] a_hi, b_hi;
  logic signed [LO_W:0]   a_lo, b_lo;
  assign a_hi = s1_r.a[COORD_WIDTH-1:LO_W];
  assign b_hi = s1_r.b[COORD_WIDTH-1:LO_W];
  assign a_lo = $signed({1'b0, s1_r.a[LO_W-1:0]});
  assign b_lo = $signed({1'b0, s1_r.b[LO_W-1:0]});

  // stage 2: partial products
  logic signed [PH_W-1:0] ahc_r, bhn_r, ahs_r, bhc_r;
  logic signed [PL_W-1:0] alc_r, bln_r, als_r, blc_r;
  coord_t                 p2_r;
  logic [1:0]             ax2_r;
  logic                   f2_r, l2_r;

  logic signed [SW-1:0] sum_na, sum_nb;
  assign sum_na = ((SW'(ahc_r) + SW'(bhn_r)) <<< LO_W) + SW'(alc_r) + SW'(bln_r) + RND;
  assign sum_nb = ((SW'(ahs_r) + SW'(bhc_r)) <<< LO_W) + SW'(als_r) + SW'(blc_r) + RND;

  // stage 3: full sums
  logic signed [SW-1:0] na_r, nb_r;
  coord_t               p3_r;
  logic [1:0]           ax3_r;
  logic                 f3_r, l3_r;

  function automatic coord_t sat(input logic signed [SW-1:0] s);
    logic signed [RW-1:0] r;
    r = s[SW-1:K_FRAC];
    if (r > MAXV)      return MAXV[COORD_WIDTH-1:0];
    else if (r < MINV) return MINV[COORD_WIDTH-1:0];
    else               return r[COORD_WIDTH-1:0];
  endfunction

  coord_t ra, rb, rx_c, ry_c, rz_c;
  assign ra = sat(na_r);
  assign rb = sat(nb_r);

  always_comb begin
    case (ax3_r)
      AXIS_X: begin
        rx_c = p3_r; ry_c = ra; rz_c = rb;
      end
      AXIS_Y: begin
        rx_c = rb; ry_c = p3_r; rz_c = ra;
      end
      default: begin
        rx_c = ra; ry_c = rb; rz_c = p3_r;
      end
    endcase
  end

  // stage 4: rotated vertex
  coord_t rx_r, ry_r, rz_r;
  logic   f4_r, l4_r;

  // running box
  coord_t mn_r [3];
  coord_t mx_r [3];
  coord_t rv   [3];
  coord_t mn_nxt [3];
  coord_t mx_nxt [3];

  assign rv[0] = rx_r;
  assign rv[1] = ry_r;
  assign rv[2] = rz_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mn_nxt[i] = (f4_r || rv[i] < mn_r[i]) ? rv[i] : mn_r[i];
      mx_nxt[i] = (f4_r || rv[i] > mx_r[i]) ? rv[i] : mx_r[i];
    end
  end

  out_item_t out_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        mn_r[i] <= '0;
        mx_r[i] <= '0;
      end
    end else if (adv) begin
      v1_r        <= fifo_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
      if (v4_r) begin
        for (int i = 0; i < 3; i++) begin
          mn_r[i] <= mn_nxt[i];
          mx_r[i] <= mx_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= fifo_data;
      ahc_r <= PH_W'(a_hi) * PH_W'(s1_r.kc);
      bhn_r <= PH_W'(b_hi) * PH_W'(s1_r.nks);
      ahs_r <= PH_W'(a_hi) * PH_W'(s1_r.ks);
      bhc_r <= PH_W'(b_hi) * PH_W'(s1_r.kc);
      alc_r <= PL_W'(a_lo) * PL_W'(s1_r.kc);
      bln_r <= PL_W'(b_lo) * PL_W'(s1_r.nks);
      als_r <= PL_W'(a_lo) * PL_W'(s1_r.ks);
      blc_r <= PL_W'(b_lo) * PL_W'(s1_r.kc);
      p2_r  <= s1_r.p;
      ax2_r <= s1_r.axis;
      f2_r  <= s1_r.first;
      l2_r  <= s1_r.last;
      na_r  <= sum_na;
      nb_r  <= sum_nb;
      p3_r  <= p2_r;
      ax3_r <= ax2_r;
      f3_r  <= f2_r;
      l3_r  <= l2_r;
      rx_r  <= rx_c;
      ry_r  <= ry_c;
      rz_r  <= rz_c;
      f4_r  <= f3_r;
      l4_r  <= l3_r;
      out_r.rotated_x <= rx_r;
      out_r.rotated_y <= ry_r;
      out_r.rotated_z <= rz_r;
      out_r.box_min_x <= mn_nxt[0];
      out_r.box_min_y <= mn_nxt[1];
      out_r.box_min_z <= mn_nxt[2];
      out_r.box_max_x <= mx_nxt[0];
      out_r.box_max_y <= mx_nxt[1];
      out_r.box_max_z <= mx_nxt[2];
      out_r.pass_done <= l4_r;
    end
  end

endmodule

### rtl/core/vertex_axis_rotation_with_bounds_core.sv
// an accepted item is written into a queue slot at the accepting edge, then
// passes the operand stage, partial products, sums, rounding and saturation,
// and box update before its result is offered
// throughput: one item per cycle while in_stall is low; an angle write holds
// in_stall while the shared series unit runs its eleven terms
// reset: synchronous, active low; box cleared to zero, sine 0, cosine one, axis x
module vertex_axis_rotation_with_bounds_core
  import vart_pkg::*;
#(
  parameter int QUEUE_DEPTH = FIFO_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // vertex items
  input  logic                   in_valid,
  input  in_item_t               in_item,
  output logic                   in_stall,
  // rotated items with box
  output logic                   out_valid,
  output out_item_t              out_item,
  input  logic                   out_stall,
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [ANGLE_WIDTH-1:0] cfg_data
);

  // register decode: writes are always taken
  logic cfg_we, angle_we, axis_we;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign angle_we  = cfg_we && (cfg_index == CFG_ANGLE);
  assign axis_we   = cfg_we && (cfg_index == CFG_AXIS);

  // sine and cosine of the written angle, ready before the next pass opens
  logic     sc_busy;
  sc_pair_t sc_pair;

  vart_sincos u_sincos (
    .clk   (clk),
    .rst_n (rst_n),
    .start (angle_we),
    .angle (cfg_data),
    .busy  (sc_busy),
    .pair  (sc_pair)
  );

  // front: accepts, picks the turning pair, attaches coefficients
  logic    push, fifo_full, pop, fifo_valid;
  q_item_t push_item, pop_item;

  vart_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .axis_we    (axis_we),
    .axis_wdata (cfg_data[1:0]),
    .sc_busy    (sc_busy),
    .sc_pair    (sc_pair),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_item  (push_item)
  );

  // short queue decoupling front from the arithmetic line
  vart_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wdata    (push_item),
    .full     (fifo_full),
    .pop      (pop),
    .rdata    (pop_item),
    .nonempty (fifo_valid)
  );

  // back: multiply, round, saturate, track the box
  vart_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_valid (fifo_valid),
    .fifo_data  (pop_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
